// ===== hdl/fmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmsp_pkg
// Shared types, register map, kind codes and fixed-point constants for the
// filter mode switch policy block. Fractions carry 8 fraction bits.
// ----------------------------------------------------------------------------
package fmsp_pkg;

    localparam int FACT_W   = 11;   // raw signed fact width
    localparam int UNIT_W   = 9;    // clamped fraction, 0 .. 256
    localparam int UTIL_W   = 10;   // saturated utility
    localparam int SUM_W    = 12;   // working width of a utility sum
    localparam int KIND_W   = 3;
    localparam int TICK_W   = 8;
    localparam int LEVEL_W  = 9;    // margin and confidence threshold
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_NONE   = 3'd0;
    localparam kind_t KIND_EMA    = 3'd1;
    localparam kind_t KIND_MEDIAN = 3'd2;
    localparam kind_t KIND_HYST   = 3'd3;
    localparam kind_t KIND_HYBRID = 3'd4;

    typedef enum logic [2:0] {
        REG_MIN_COMMIT    = 3'd0,
        REG_SWITCH_MARGIN = 3'd1,
        REG_CONF_THRESH   = 3'd2,
        REG_STABLE_KIND   = 3'd3,
        REG_SPIKE_KIND    = 3'd4,
        REG_STEP_KIND     = 3'd5,
        REG_DRIFT_KIND    = 3'd6,
        REG_MIXED_KIND    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0]  hold_ticks;
        logic [LEVEL_W-1:0] gain_margin;
        logic [LEVEL_W-1:0] conf_floor;
        kind_t              stable_kind;
        kind_t              spike_kind;
        kind_t              step_kind;
        kind_t              drift_kind;
        kind_t              mixed_kind;
    } cfg_t;

    // Facts after the facts_present substitution, still unclamped
    typedef struct packed {
        logic signed [FACT_W-1:0] spike;
        logic signed [FACT_W-1:0] jitter;
        logic signed [FACT_W-1:0] conf;
        logic                     step;
        logic                     drift;
        logic                     outl;
    } facts_t;

    // Facts clamped to [0, 1.0] for scoring
    typedef struct packed {
        logic [UNIT_W-1:0] s;
        logic [UNIT_W-1:0] j;
        logic [UNIT_W-1:0] c;
        logic              step;
        logic              drift;
        logic              outl;
    } unit_t;

    typedef struct packed {
        kind_t                    prior_kind;
        kind_t                    chosen_kind;
        logic signed [UTIL_W-1:0] preferred_utility;
        logic signed [UTIL_W-1:0] prior_utility;
        logic                     held_low_confidence;
        logic                     held_commit;
        logic                     held_margin;
        logic                     did_switch;
    } result_t;

    // Register reset values
    localparam logic [TICK_W-1:0]  RST_MIN_COMMIT  = 8'd8;
    localparam logic [LEVEL_W-1:0] RST_MARGIN      = 9'd38;
    localparam logic [LEVEL_W-1:0] RST_CONF_THRESH = 9'd115;
    localparam kind_t              RST_STABLE_KIND = KIND_HYST;
    localparam kind_t              RST_SPIKE_KIND  = KIND_MEDIAN;
    localparam kind_t              RST_STEP_KIND   = KIND_EMA;
    localparam kind_t              RST_DRIFT_KIND  = KIND_EMA;
    localparam kind_t              RST_MIXED_KIND  = KIND_HYBRID;

    // Fixed-point constants
    localparam logic [UNIT_W-1:0]        FX_ONE      = 9'd256;
    localparam logic signed [FACT_W-1:0] FX_ONE_S    = 11'sd256;
    localparam logic signed [FACT_W-1:0] FACT_ZERO   = 11'sd0;
    localparam logic signed [FACT_W-1:0] SPIKE_HIGH  = 11'sd154;   // 0.6
    localparam logic signed [FACT_W-1:0] SPIKE_MOD   = 11'sd90;    // 0.35
    localparam logic signed [FACT_W-1:0] JITTER_HIGH = 11'sd154;   // 0.6

    localparam logic [7:0] W_WEAK    = 8'd38;   // 0.15
    localparam logic [7:0] W_MED_S   = 8'd218;  // 0.85
    localparam logic [7:0] W_MED_J   = 8'd90;   // 0.35
    localparam logic [7:0] W_HYB_S   = 8'd192;  // 0.75
    localparam logic [7:0] W_HYB_J   = 8'd77;   // 0.30
    localparam logic [7:0] W_HYB_C   = 8'd51;   // 0.2
    localparam logic [7:0] W_EMA_S   = 8'd64;   // 0.25
    localparam logic [7:0] W_EMA_C   = 8'd26;   // 0.1

    localparam logic signed [SUM_W-1:0] SUM_ZERO      = 12'sd0;
    localparam logic signed [SUM_W-1:0] B_HYST_DRIFT  = 12'sd64;
    localparam logic signed [SUM_W-1:0] B_HYST_STEP   = 12'sd38;
    localparam logic signed [SUM_W-1:0] B_MED_OUTL    = 12'sd26;
    localparam logic signed [SUM_W-1:0] B_MED_STEP    = 12'sd26;
    localparam logic signed [SUM_W-1:0] B_HYB_STEP    = 12'sd90;
    localparam logic signed [SUM_W-1:0] B_HYB_DRIFT   = 12'sd51;
    localparam logic signed [SUM_W-1:0] B_EMA_STEP    = 12'sd128;
    localparam logic signed [SUM_W-1:0] B_EMA_DRIFT   = 12'sd115;
    localparam logic signed [SUM_W-1:0] SUM_SAT_MIN   = -12'sd512;
    localparam logic signed [SUM_W-1:0] SUM_SAT_MAX   = 12'sd511;
    localparam logic signed [UTIL_W-1:0] UTIL_MIN     = 10'sh200;
    localparam logic signed [UTIL_W-1:0] UTIL_MAX     = 10'sh1FF;
    localparam logic signed [UTIL_W-1:0] UTIL_NONE    = -10'sd256;

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [FACT_W-1:0] x);
        logic [UNIT_W-1:0] r;
        if (x < FACT_ZERO) begin
            r = '0;
        end else if (x > FX_ONE_S) begin
            r = FX_ONE;
        end else begin
            r = x[UNIT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/fmsp_regs.sv =====
// ----------------------------------------------------------------------------
// fmsp_regs
// APB register file holding the commit hold, margin, confidence threshold
// and the five configured filter kinds.
// ----------------------------------------------------------------------------
module fmsp_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fmsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [fmsp_pkg::DATA_W-1:0]  pwdata,
    output logic [fmsp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output fmsp_pkg::cfg_t               cfg
);

    fmsp_pkg::cfg_t     cfg_reg;
    fmsp_pkg::cfg_t     cfg_next;
    fmsp_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = fmsp_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                fmsp_pkg::REG_MIN_COMMIT:    cfg_next.hold_ticks = pwdata[7:0];
                fmsp_pkg::REG_SWITCH_MARGIN: cfg_next.gain_margin = pwdata[8:0];
                fmsp_pkg::REG_CONF_THRESH:   cfg_next.conf_floor = pwdata[8:0];
                fmsp_pkg::REG_STABLE_KIND:   cfg_next.stable_kind = pwdata[2:0];
                fmsp_pkg::REG_SPIKE_KIND:    cfg_next.spike_kind = pwdata[2:0];
                fmsp_pkg::REG_STEP_KIND:     cfg_next.step_kind = pwdata[2:0];
                fmsp_pkg::REG_DRIFT_KIND:    cfg_next.drift_kind = pwdata[2:0];
                fmsp_pkg::REG_MIXED_KIND:    cfg_next.mixed_kind = pwdata[2:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks  <= fmsp_pkg::RST_MIN_COMMIT;
            cfg_reg.gain_margin <= fmsp_pkg::RST_MARGIN;
            cfg_reg.conf_floor  <= fmsp_pkg::RST_CONF_THRESH;
            cfg_reg.stable_kind <= fmsp_pkg::RST_STABLE_KIND;
            cfg_reg.spike_kind  <= fmsp_pkg::RST_SPIKE_KIND;
            cfg_reg.step_kind   <= fmsp_pkg::RST_STEP_KIND;
            cfg_reg.drift_kind  <= fmsp_pkg::RST_DRIFT_KIND;
            cfg_reg.mixed_kind  <= fmsp_pkg::RST_MIXED_KIND;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            fmsp_pkg::REG_MIN_COMMIT:    prdata = 32'(cfg_reg.hold_ticks);
            fmsp_pkg::REG_SWITCH_MARGIN: prdata = 32'(cfg_reg.gain_margin);
            fmsp_pkg::REG_CONF_THRESH:   prdata = 32'(cfg_reg.conf_floor);
            fmsp_pkg::REG_STABLE_KIND:   prdata = 32'(cfg_reg.stable_kind);
            fmsp_pkg::REG_SPIKE_KIND:    prdata = 32'(cfg_reg.spike_kind);
            fmsp_pkg::REG_STEP_KIND:     prdata = 32'(cfg_reg.step_kind);
            fmsp_pkg::REG_DRIFT_KIND:    prdata = 32'(cfg_reg.drift_kind);
            fmsp_pkg::REG_MIXED_KIND:    prdata = 32'(cfg_reg.mixed_kind);
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/fmsp_score.sv =====
// ----------------------------------------------------------------------------
// fmsp_score
// Utility of one filter kind for the clamped facts of the current request,
// saturated to the signed 10-bit range.
// ----------------------------------------------------------------------------
module fmsp_score (
    input  fmsp_pkg::kind_t                        kind,
    input  fmsp_pkg::unit_t                        f,
    output logic signed [fmsp_pkg::UTIL_W-1:0]     utility
);

    logic [fmsp_pkg::UNIT_W-1:0]     s_inv;
    logic [fmsp_pkg::UNIT_W-1:0]     j_inv;
    logic [fmsp_pkg::UNIT_W-1:0]     c_inv;
    logic [17:0]                     p_hyst;
    logic [16:0]                     p_weak;
    logic [16:0]                     p_med_s;
    logic [16:0]                     p_med_j;
    logic [16:0]                     p_hyb_s;
    logic [16:0]                     p_hyb_j;
    logic [16:0]                     p_hyb_c;
    logic [16:0]                     p_ema_s;
    logic [16:0]                     p_ema_c;
    logic signed [fmsp_pkg::SUM_W-1:0] doubt;
    logic signed [fmsp_pkg::SUM_W-1:0] u;
    logic                            no_kind;

    always_comb begin
        s_inv   = fmsp_pkg::FX_ONE - f.s;
        j_inv   = fmsp_pkg::FX_ONE - f.j;
        c_inv   = fmsp_pkg::FX_ONE - f.c;
        p_hyst  = 18'(s_inv) * 18'(j_inv);
        p_weak  = 17'(c_inv) * 17'(fmsp_pkg::W_WEAK);
        p_med_s = 17'(f.s) * 17'(fmsp_pkg::W_MED_S);
        p_med_j = 17'(f.j) * 17'(fmsp_pkg::W_MED_J);
        p_hyb_s = 17'(f.s) * 17'(fmsp_pkg::W_HYB_S);
        p_hyb_j = 17'(f.j) * 17'(fmsp_pkg::W_HYB_J);
        p_hyb_c = 17'(f.c) * 17'(fmsp_pkg::W_HYB_C);
        p_ema_s = 17'(s_inv) * 17'(fmsp_pkg::W_EMA_S);
        p_ema_c = 17'(f.c) * 17'(fmsp_pkg::W_EMA_C);
        doubt   = $signed(12'(p_weak[16:8]));
        no_kind = 1'b0;

        case (kind)
            fmsp_pkg::KIND_HYST: begin
                u = $signed(12'(p_hyst[17:8]))
                    - (f.drift ? fmsp_pkg::B_HYST_DRIFT : fmsp_pkg::SUM_ZERO)
                    - (f.step  ? fmsp_pkg::B_HYST_STEP  : fmsp_pkg::SUM_ZERO)
                    - doubt;
            end
            fmsp_pkg::KIND_MEDIAN: begin
                u = $signed(12'(p_med_s[16:8])) + $signed(12'(p_med_j[16:8]))
                    + (f.outl ? fmsp_pkg::B_MED_OUTL : fmsp_pkg::SUM_ZERO)
                    - (f.step ? fmsp_pkg::B_MED_STEP : fmsp_pkg::SUM_ZERO)
                    - doubt;
            end
            fmsp_pkg::KIND_HYBRID: begin
                u = $signed(12'(p_hyb_s[16:8])) + $signed(12'(p_hyb_j[16:8]))
                    + (f.step  ? fmsp_pkg::B_HYB_STEP  : fmsp_pkg::SUM_ZERO)
                    + (f.drift ? fmsp_pkg::B_HYB_DRIFT : fmsp_pkg::SUM_ZERO)
                    + $signed(12'(p_hyb_c[16:8]));
            end
            fmsp_pkg::KIND_EMA: begin
                u = (f.step  ? fmsp_pkg::B_EMA_STEP  : fmsp_pkg::SUM_ZERO)
                    + (f.drift ? fmsp_pkg::B_EMA_DRIFT : fmsp_pkg::SUM_ZERO)
                    + $signed(12'(p_ema_s[16:8])) + $signed(12'(p_ema_c[16:8]));
            end
            default: begin
                // none and the unused codes score a flat -1.0
                u       = fmsp_pkg::SUM_ZERO;
                no_kind = 1'b1;
            end
        endcase

        if (no_kind) begin
            utility = fmsp_pkg::UTIL_NONE;
        end else if (u < fmsp_pkg::SUM_SAT_MIN) begin
            utility = fmsp_pkg::UTIL_MIN;
        end else if (u > fmsp_pkg::SUM_SAT_MAX) begin
            utility = fmsp_pkg::UTIL_MAX;
        end else begin
            utility = u[fmsp_pkg::UTIL_W-1:0];
        end
    end

endmodule

// ===== hdl/fmsp_decide.sv =====
// ----------------------------------------------------------------------------
// fmsp_decide
// Preferred kind selection, hold checks and the active kind / commit hold
// state. State moves on each request handed to the result register.
// ----------------------------------------------------------------------------
module fmsp_decide (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   advance,
    input  fmsp_pkg::cfg_t                         cfg,
    input  fmsp_pkg::facts_t                       facts,
    input  logic signed [fmsp_pkg::UTIL_W-1:0]     pref_utility,
    input  logic signed [fmsp_pkg::UTIL_W-1:0]     prior_utility,
    output fmsp_pkg::kind_t                        pref_kind,
    output fmsp_pkg::kind_t                        prior_kind,
    output fmsp_pkg::result_t                      result
);

    fmsp_pkg::kind_t                 active_kind_reg;
    fmsp_pkg::kind_t                 active_kind_next;
    logic                            started_reg;
    logic                            started_next;
    logic [fmsp_pkg::TICK_W-1:0]     commit_left_reg;
    logic [fmsp_pkg::TICK_W-1:0]     commit_left_next;
    logic [fmsp_pkg::TICK_W-1:0]     commit_base;
    logic signed [fmsp_pkg::SUM_W-1:0] conf_ext;
    logic signed [fmsp_pkg::SUM_W-1:0] thresh_ext;
    logic signed [fmsp_pkg::SUM_W-1:0] pref_ext;
    logic signed [fmsp_pkg::SUM_W-1:0] need_ext;
    logic                            h_conf;
    logic                            h_commit;
    logic                            h_margin;
    logic                            sw;

    assign prior_kind = active_kind_reg;

    // Step and drift flags outrank the spike and jitter levels
    always_comb begin
        if (facts.step) begin
            pref_kind = cfg.step_kind;
        end else if (facts.drift) begin
            pref_kind = cfg.drift_kind;
        end else if (facts.spike >= fmsp_pkg::SPIKE_HIGH) begin
            pref_kind = cfg.spike_kind;
        end else if (facts.spike >= fmsp_pkg::SPIKE_MOD ||
                     facts.jitter >= fmsp_pkg::JITTER_HIGH) begin
            pref_kind = cfg.mixed_kind;
        end else begin
            pref_kind = cfg.stable_kind;
        end
    end

    always_comb begin
        conf_ext   = $signed({facts.conf[fmsp_pkg::FACT_W-1], facts.conf});
        thresh_ext = $signed({3'b000, cfg.conf_floor});
        pref_ext   = $signed({{2{pref_utility[fmsp_pkg::UTIL_W-1]}}, pref_utility});
        need_ext   = $signed({{2{prior_utility[fmsp_pkg::UTIL_W-1]}}, prior_utility})
                     + $signed({3'b000, cfg.gain_margin});

        active_kind_next = active_kind_reg;
        started_next     = 1'b1;
        h_conf           = 1'b0;
        h_commit         = 1'b0;
        h_margin         = 1'b0;
        sw               = 1'b0;

        if (!started_reg) begin
            // first request adopts the preferred kind outright
            active_kind_next = pref_kind;
        end else if (pref_kind != active_kind_reg) begin
            if (conf_ext < thresh_ext) begin
                h_conf = 1'b1;
            end else if (commit_left_reg != '0) begin
                h_commit = 1'b1;
            end else if (pref_ext < need_ext) begin
                h_margin = 1'b1;
            end else begin
                active_kind_next = pref_kind;
                sw               = 1'b1;
            end
        end

        // a fresh hold is counted down on the request that loads it
        commit_base      = sw ? cfg.hold_ticks : commit_left_reg;
        commit_left_next = (commit_base != '0) ? commit_base - 8'd1 : '0;
    end

    always_comb begin
        result.prior_kind          = active_kind_reg;
        result.chosen_kind         = active_kind_next;
        result.preferred_utility   = pref_utility;
        result.prior_utility       = prior_utility;
        result.held_low_confidence = h_conf;
        result.held_commit         = h_commit;
        result.held_margin         = h_margin;
        result.did_switch          = sw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_kind_reg <= fmsp_pkg::KIND_NONE;
            started_reg     <= 1'b0;
            commit_left_reg <= '0;
        end else if (advance) begin
            active_kind_reg <= active_kind_next;
            started_reg     <= started_next;
            commit_left_reg <= commit_left_next;
        end
    end

endmodule

// ===== hdl/filter_mode_switch_policy_core.sv =====
// ----------------------------------------------------------------------------
// filter_mode_switch_policy_core
// Per-sample filter kind policy: scores the preferred and active kinds and
// switches only past the confidence, commit hold and margin checks.
// ----------------------------------------------------------------------------
// Use:
//   s_axis carries one request of measurement facts per sample; tuser is
//   facts_present. m_axis returns one decision per request, in order.
//   The APB port sets the commit hold, margin, confidence threshold and the
//   five configured kinds; write it only while no request is in flight.
// Timing:
//   A request sits in the input register, is scored and decided
//   combinationally and lands in the result register, from which
//   m_axis_tvalid is driven. One request per cycle is sustained while
//   m_axis_tready stays high; the rate is set by the active kind and commit
//   hold registers, which update in the same cycle as the decision that
//   reads them.
// Reset:
//   aresetn clears both stage valids, the active kind to none, the started
//   flag and the commit hold, and loads the register defaults.
// Stall:
//   With m_axis_tready low the result holds, the input register still takes
//   one more request, then s_axis_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module filter_mode_switch_policy_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fmsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [fmsp_pkg::DATA_W-1:0]  pwdata,
    output logic [fmsp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // facts in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [10:0] spike_rate, [21:11] jitter_level, [32:22] confidence_level,
    // [33] step_suspected, [34] drift_seen, [35] outliers_seen, [39:36] zero
    input  logic [39:0]                  s_axis_tdata,
    // [0] facts_present
    input  logic                         s_axis_tuser,
    // decision out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [2:0] prior_kind, [5:3] chosen_kind, [15:6] preferred_utility,
    // [25:16] prior_utility, [26] held_low_confidence, [27] held_commit,
    // [28] held_margin, [29] did_switch, [31:30] zero
    output logic [31:0]                  m_axis_tdata
);

    fmsp_pkg::cfg_t    cfg;
    fmsp_pkg::facts_t  in_facts_reg;
    logic              in_present_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    fmsp_pkg::facts_t  facts;
    fmsp_pkg::unit_t   unit;
    fmsp_pkg::kind_t   pref_kind;
    fmsp_pkg::kind_t   prior_kind;
    logic signed [fmsp_pkg::UTIL_W-1:0] pref_utility;
    logic signed [fmsp_pkg::UTIL_W-1:0] prior_utility;
    fmsp_pkg::result_t result;
    fmsp_pkg::result_t out_result_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              s_accept;
    logic              advance;

    fmsp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: advance when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_present_reg      <= s_axis_tuser;
            in_facts_reg.spike  <= s_axis_tdata[10:0];
            in_facts_reg.jitter <= s_axis_tdata[21:11];
            in_facts_reg.conf   <= s_axis_tdata[32:22];
            in_facts_reg.step   <= s_axis_tdata[33];
            in_facts_reg.drift  <= s_axis_tdata[34];
            in_facts_reg.outl   <= s_axis_tdata[35];
        end
    end

    // Absent facts read as calm, fully confident, no flags
    always_comb begin
        facts.spike  = in_present_reg ? in_facts_reg.spike  : fmsp_pkg::FACT_ZERO;
        facts.jitter = in_present_reg ? in_facts_reg.jitter : fmsp_pkg::FACT_ZERO;
        facts.conf   = in_present_reg ? in_facts_reg.conf   : fmsp_pkg::FX_ONE_S;
        facts.step   = in_present_reg && in_facts_reg.step;
        facts.drift  = in_present_reg && in_facts_reg.drift;
        facts.outl   = in_present_reg && in_facts_reg.outl;

        unit.s     = fmsp_pkg::clamp_unit(facts.spike);
        unit.j     = fmsp_pkg::clamp_unit(facts.jitter);
        unit.c     = fmsp_pkg::clamp_unit(facts.conf);
        unit.step  = facts.step;
        unit.drift = facts.drift;
        unit.outl  = facts.outl;
    end

    fmsp_score u_score_pref (
        .kind    (pref_kind),
        .f       (unit),
        .utility (pref_utility)
    );

    fmsp_score u_score_prior (
        .kind    (prior_kind),
        .f       (unit),
        .utility (prior_utility)
    );

    fmsp_decide u_decide (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .cfg           (cfg),
        .facts         (facts),
        .pref_utility  (pref_utility),
        .prior_utility (prior_utility),
        .pref_kind     (pref_kind),
        .prior_kind    (prior_kind),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_result_reg.did_switch,
                            out_result_reg.held_margin,
                            out_result_reg.held_commit,
                            out_result_reg.held_low_confidence,
                            out_result_reg.prior_utility,
                            out_result_reg.preferred_utility,
                            out_result_reg.chosen_kind,
                            out_result_reg.prior_kind};

endmodule

// ===== hdl/fmsp_checker.sv =====
// ----------------------------------------------------------------------------
// fmsp_checker
// Port-level checks on the decision stream of the policy core.
// ----------------------------------------------------------------------------
module fmsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled decision holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("decision changed while stalled");

    // At most one of the hold reasons and the switch flag per decision
    a_one_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $countones(m_axis_tdata[29:26]) <= 1)
        else $error("more than one hold or switch flag set");

    // A switch changes the kind
    a_switch_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[5:3] != m_axis_tdata[2:0])
        else $error("switch reported without a kind change");

    // A hold keeps the kind
    a_hold_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[26] || m_axis_tdata[27] || m_axis_tdata[28])
        |-> m_axis_tdata[5:3] == m_axis_tdata[2:0])
        else $error("kind changed under a hold");

endmodule

bind filter_mode_switch_policy_core fmsp_checker u_fmsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/filter_mode_switch_policy_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filter_mode_switch_policy_core_test
// Drives measurement facts into the policy core and checks every decision.
// A shadow policy follows the register writes, scores the preferred and
// active kinds and tracks the commit hold. Each decision is compared field
// by field in order. Stimulus covers directed corner cases, undefined kind
// codes, register extremes, random traffic with random idling, a long
// output stall and an idle-free stretch at the end.
// ----------------------------------------------------------------------------
module filter_mode_switch_policy_core_test;

    typedef struct {
        bit                                 present;
        logic signed [fmsp_pkg::FACT_W-1:0] spike;
        logic signed [fmsp_pkg::FACT_W-1:0] jitter;
        logic signed [fmsp_pkg::FACT_W-1:0] conf;
        bit                                 step;
        bit                                 drift;
        bit                                 outl;
    } facts_req_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fmsp_pkg::ADDR_W-1:0]   paddr;
    logic [fmsp_pkg::DATA_W-1:0]   pwdata;
    logic [fmsp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // [10:0] spike_rate, [21:11] jitter_level, [32:22] confidence_level,
    // [33] step_suspected, [34] drift_seen, [35] outliers_seen, [39:36] zero
    logic [39:0]                   s_axis_tdata;
    // [0] facts_present
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // [2:0] prior_kind, [5:3] chosen_kind, [15:6] preferred_utility,
    // [25:16] prior_utility, [26] held_low_confidence, [27] held_commit,
    // [28] held_margin, [29] did_switch, [31:30] zero
    logic [31:0]                   m_axis_tdata;

    // Shadow policy state
    fmsp_pkg::cfg_t               policy_cfg;
    fmsp_pkg::kind_t              cur_kind;
    bit                           policy_started;
    logic [fmsp_pkg::TICK_W-1:0]  commit_hold;

    fmsp_pkg::result_t  decision_q[$];
    int                 mismatch_count;
    bit                 src_idle_en;
    bit                 sink_idle_en;
    int                 sink_hold_cycles;

    filter_mode_switch_policy_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(6_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow policy
    // ------------------------------------------------------------------
    function automatic int unit_clamp(int x);
        if (x < 0) begin
            return 0;
        end
        if (x > 256) begin
            return 256;
        end
        return x;
    endfunction

    function automatic int kind_utility(fmsp_pkg::kind_t k, int sp, int ji, int co,
                                        bit step, bit drift, bit outl);
        int s;
        int j;
        int c;
        int doubt;
        int u;
        s = unit_clamp(sp);
        j = unit_clamp(ji);
        c = unit_clamp(co);
        doubt = ((256 - c) * 38) >> 8;
        case (k)
            fmsp_pkg::KIND_HYST: begin
                u = (((256 - s) * (256 - j)) >> 8) - (drift ? 64 : 0)
                    - (step ? 38 : 0) - doubt;
            end
            fmsp_pkg::KIND_MEDIAN: begin
                u = ((s * 218) >> 8) + ((j * 90) >> 8) + (outl ? 26 : 0)
                    - (step ? 26 : 0) - doubt;
            end
            fmsp_pkg::KIND_HYBRID: begin
                u = ((s * 192) >> 8) + ((j * 77) >> 8) + (step ? 90 : 0)
                    + (drift ? 51 : 0) + ((c * 51) >> 8);
            end
            fmsp_pkg::KIND_EMA: begin
                u = (step ? 128 : 0) + (drift ? 115 : 0) + (((256 - s) * 64) >> 8)
                    + ((c * 26) >> 8);
            end
            default: begin
                u = -256;
            end
        endcase
        if (u < -512) begin
            u = -512;
        end else if (u > 511) begin
            u = 511;
        end
        return u;
    endfunction

    task automatic predict_decision(input facts_req_t f);
        int                sp;
        int                ji;
        int                co;
        bit                step;
        bit                drift;
        bit                outl;
        fmsp_pkg::kind_t   pref;
        int                pu;
        int                qu;
        fmsp_pkg::result_t d;
        sp    = f.present ? int'(f.spike) : 0;
        ji    = f.present ? int'(f.jitter) : 0;
        co    = f.present ? int'(f.conf) : 256;
        step  = f.present && f.step;
        drift = f.present && f.drift;
        outl  = f.present && f.outl;

        // raw values pick the kind, clamped ones score it
        if (step) begin
            pref = policy_cfg.step_kind;
        end else if (drift) begin
            pref = policy_cfg.drift_kind;
        end else if (sp >= 154) begin
            pref = policy_cfg.spike_kind;
        end else if (sp >= 90 || ji >= 154) begin
            pref = policy_cfg.mixed_kind;
        end else begin
            pref = policy_cfg.stable_kind;
        end

        pu = kind_utility(pref, sp, ji, co, step, drift, outl);
        qu = kind_utility(cur_kind, sp, ji, co, step, drift, outl);
        d = '0;
        d.prior_kind        = cur_kind;
        d.preferred_utility = pu[fmsp_pkg::UTIL_W-1:0];
        d.prior_utility     = qu[fmsp_pkg::UTIL_W-1:0];

        if (!policy_started) begin
            cur_kind       = pref;
            policy_started = 1'b1;
        end else if (pref != cur_kind) begin
            if (co < int'(policy_cfg.conf_floor)) begin
                d.held_low_confidence = 1'b1;
            end else if (commit_hold != 0) begin
                d.held_commit = 1'b1;
            end else if (pu < qu + int'(policy_cfg.gain_margin)) begin
                d.held_margin = 1'b1;
            end else begin
                cur_kind     = pref;
                commit_hold  = policy_cfg.hold_ticks;
                d.did_switch = 1'b1;
            end
        end
        if (commit_hold != 0) begin
            commit_hold = commit_hold - 8'd1;
        end
        d.chosen_kind = cur_kind;
        decision_q.push_back(d);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: decision %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    initial begin
        fmsp_pkg::result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (decision_q.size() == 0) begin
                    report_mismatch("with none pending", int'(m_axis_tdata), 0);
                end else begin
                    want = decision_q.pop_front();
                    if (m_axis_tdata[2:0] != want.prior_kind)
                        report_mismatch("prior_kind", int'(m_axis_tdata[2:0]),
                                        int'(want.prior_kind));
                    if (m_axis_tdata[5:3] != want.chosen_kind)
                        report_mismatch("chosen_kind", int'(m_axis_tdata[5:3]),
                                        int'(want.chosen_kind));
                    if (m_axis_tdata[15:6] != want.preferred_utility)
                        report_mismatch("preferred_utility",
                                        int'($signed(m_axis_tdata[15:6])),
                                        int'(want.preferred_utility));
                    if (m_axis_tdata[25:16] != want.prior_utility)
                        report_mismatch("prior_utility",
                                        int'($signed(m_axis_tdata[25:16])),
                                        int'(want.prior_utility));
                    if (m_axis_tdata[26] != want.held_low_confidence)
                        report_mismatch("held_low_confidence", int'(m_axis_tdata[26]),
                                        int'(want.held_low_confidence));
                    if (m_axis_tdata[27] != want.held_commit)
                        report_mismatch("held_commit", int'(m_axis_tdata[27]),
                                        int'(want.held_commit));
                    if (m_axis_tdata[28] != want.held_margin)
                        report_mismatch("held_margin", int'(m_axis_tdata[28]),
                                        int'(want.held_margin));
                    if (m_axis_tdata[29] != want.did_switch)
                        report_mismatch("did_switch", int'(m_axis_tdata[29]),
                                        int'(want.did_switch));
                end
            end
        end
    end

    // Receiver: long hold-offs first, then random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic sender_pause(input int cycles);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic send_facts(input facts_req_t f);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            sender_pause($urandom_range(1, 16));
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = f.present;
        s_axis_tdata  = {4'b0, f.outl, f.drift, f.step, f.conf, f.jitter, f.spike};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        predict_decision(f);
    endtask

    // Drop the request line and hold until every decision is back
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (decision_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input fmsp_pkg::reg_idx_t idx,
                             input logic [fmsp_pkg::DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        case (idx)
            fmsp_pkg::REG_MIN_COMMIT:
                policy_cfg.hold_ticks  = value[fmsp_pkg::TICK_W-1:0];
            fmsp_pkg::REG_SWITCH_MARGIN:
                policy_cfg.gain_margin = value[fmsp_pkg::LEVEL_W-1:0];
            fmsp_pkg::REG_CONF_THRESH:
                policy_cfg.conf_floor  = value[fmsp_pkg::LEVEL_W-1:0];
            fmsp_pkg::REG_STABLE_KIND:
                policy_cfg.stable_kind = value[fmsp_pkg::KIND_W-1:0];
            fmsp_pkg::REG_SPIKE_KIND:
                policy_cfg.spike_kind  = value[fmsp_pkg::KIND_W-1:0];
            fmsp_pkg::REG_STEP_KIND:
                policy_cfg.step_kind   = value[fmsp_pkg::KIND_W-1:0];
            fmsp_pkg::REG_DRIFT_KIND:
                policy_cfg.drift_kind  = value[fmsp_pkg::KIND_W-1:0];
            default:
                policy_cfg.mixed_kind  = value[fmsp_pkg::KIND_W-1:0];
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_policy(input fmsp_pkg::cfg_t c);
        wait_drained();
        apb_write(fmsp_pkg::REG_MIN_COMMIT, 32'(c.hold_ticks));
        apb_write(fmsp_pkg::REG_SWITCH_MARGIN, 32'(c.gain_margin));
        apb_write(fmsp_pkg::REG_CONF_THRESH, 32'(c.conf_floor));
        apb_write(fmsp_pkg::REG_STABLE_KIND, 32'(c.stable_kind));
        apb_write(fmsp_pkg::REG_SPIKE_KIND, 32'(c.spike_kind));
        apb_write(fmsp_pkg::REG_STEP_KIND, 32'(c.step_kind));
        apb_write(fmsp_pkg::REG_DRIFT_KIND, 32'(c.drift_kind));
        apb_write(fmsp_pkg::REG_MIXED_KIND, 32'(c.mixed_kind));
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic facts_req_t mk_facts(bit present, int sp, int ji, int co,
                                            bit step, bit drift, bit outl);
        facts_req_t f;
        f.present = present;
        f.spike   = sp[fmsp_pkg::FACT_W-1:0];
        f.jitter  = ji[fmsp_pkg::FACT_W-1:0];
        f.conf    = co[fmsp_pkg::FACT_W-1:0];
        f.step    = step;
        f.drift   = drift;
        f.outl    = outl;
        return f;
    endfunction

    function automatic int random_fact(input int lo, input int hi);
        logic [fmsp_pkg::FACT_W-1:0] raw;
        int                          rnd;
        int                          pick;
        pick = $urandom_range(0, 9);
        rnd  = $urandom;
        raw  = rnd[fmsp_pkg::FACT_W-1:0];
        if (pick < 6) begin
            return $urandom_range(lo, hi);
        end else if (pick < 8) begin
            // sit near the selection thresholds
            return $urandom_range(80, 170);
        end
        return int'($signed(raw));
    endfunction

    function automatic facts_req_t random_facts();
        facts_req_t f;
        f = mk_facts($urandom_range(0, 15) != 0, random_fact(0, 300), random_fact(0, 300),
                     random_fact(0, 520), $urandom_range(0, 5) == 0,
                     $urandom_range(0, 5) == 0, $urandom_range(0, 1) == 1);
        return f;
    endfunction

    function automatic fmsp_pkg::kind_t random_kind();
        if ($urandom_range(0, 4) == 0) begin
            return fmsp_pkg::kind_t'($urandom_range(0, 7));
        end
        return fmsp_pkg::kind_t'($urandom_range(1, 4));
    endfunction

    function automatic fmsp_pkg::cfg_t random_policy();
        fmsp_pkg::cfg_t c;
        int             ticks;
        int             gap;
        int             lvl;
        ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        gap   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 80);
        lvl   = $urandom_range(0, 300);
        c.hold_ticks  = ticks[fmsp_pkg::TICK_W-1:0];
        c.gain_margin = gap[fmsp_pkg::LEVEL_W-1:0];
        c.conf_floor  = lvl[fmsp_pkg::LEVEL_W-1:0];
        c.stable_kind = random_kind();
        c.spike_kind  = random_kind();
        c.step_kind   = random_kind();
        c.drift_kind  = random_kind();
        c.mixed_kind  = random_kind();
        return c;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_facts(random_facts());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_policy();
        // first request adopts the stable kind
        send_facts(mk_facts(1, 0, 0, 256, 0, 0, 0));
        // high spikes switch to median and start the commit hold
        send_facts(mk_facts(1, 200, 0, 256, 0, 0, 0));
        send_facts(mk_facts(1, 0, 0, 256, 1, 0, 0));
        send_facts(mk_facts(1, 0, 0, -1024, 1, 0, 0));
        // stay on median until the hold has run out
        repeat (6) send_facts(mk_facts(1, 200, 0, 256, 0, 0, 0));
        // moderate spikes: hybrid wins by less than the margin
        send_facts(mk_facts(1, 140, 0, 256, 0, 0, 0));
        send_facts(mk_facts(1, 153, 153, 256, 0, 0, 1));
        send_facts(mk_facts(1, 154, 0, 256, 0, 0, 0));
        send_facts(mk_facts(1, 89, 154, 256, 0, 0, 0));
        send_facts(mk_facts(1, 1023, 1023, 1023, 1, 1, 1));
        send_facts(mk_facts(1, -1024, -1024, -1024, 0, 0, 0));
        // absent facts must ignore whatever rides in the data
        send_facts(mk_facts(0, -1, -1, -1, 1, 1, 1));
        send_facts(mk_facts(1, 0, 0, 256, 0, 1, 0));
        send_facts(mk_facts(1, 0, 0, 114, 0, 0, 0));
        send_facts(mk_facts(1, 0, 0, 115, 0, 0, 1));
    endtask

    task automatic test_undefined_kinds();
        fmsp_pkg::cfg_t c;
        c = random_policy();
        c.stable_kind = fmsp_pkg::kind_t'(5);
        c.spike_kind  = fmsp_pkg::kind_t'(6);
        c.step_kind   = fmsp_pkg::kind_t'(7);
        c.drift_kind  = fmsp_pkg::KIND_NONE;
        c.mixed_kind  = fmsp_pkg::KIND_HYST;
        c.hold_ticks  = 8'd2;
        program_policy(c);
        send_random(60);
    endtask

    task automatic test_config_sweep();
        fmsp_pkg::cfg_t c;
        for (int phase = 0; phase < 8; phase++) begin
            c = random_policy();
            if (phase == 0) begin
                c.hold_ticks  = '0;
                c.gain_margin = '0;
                c.conf_floor  = '0;
            end else if (phase == 1) begin
                c.hold_ticks  = '1;
                c.gain_margin = '1;
                c.conf_floor  = '1;
            end
            program_policy(c);
            send_random(65);
            // let the sender rest until the pipe is empty, mid-phase
            wait_drained();
            send_random(65);
        end
    endtask

    task automatic test_backpressure();
        bit idle_was;
        idle_was    = src_idle_en;
        src_idle_en = 1'b0;
        sink_hold_cycles = 300;
        send_random(60);
        src_idle_en = idle_was;
    endtask

    task automatic test_steady_stream();
        wait_drained();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        program_policy(random_policy());
        send_random(300);
    endtask

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        mismatch_count   = 0;
        src_idle_en      = 1'b0;
        sink_idle_en     = 1'b0;
        sink_hold_cycles = 0;

        policy_cfg.hold_ticks  = fmsp_pkg::RST_MIN_COMMIT;
        policy_cfg.gain_margin = fmsp_pkg::RST_MARGIN;
        policy_cfg.conf_floor  = fmsp_pkg::RST_CONF_THRESH;
        policy_cfg.stable_kind = fmsp_pkg::RST_STABLE_KIND;
        policy_cfg.spike_kind  = fmsp_pkg::RST_SPIKE_KIND;
        policy_cfg.step_kind   = fmsp_pkg::RST_STEP_KIND;
        policy_cfg.drift_kind  = fmsp_pkg::RST_DRIFT_KIND;
        policy_cfg.mixed_kind  = fmsp_pkg::RST_MIXED_KIND;
        cur_kind       = fmsp_pkg::KIND_NONE;
        policy_started = 1'b0;
        commit_hold    = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_policy();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_undefined_kinds();
        test_config_sweep();
        test_backpressure();
        test_steady_stream();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
